/* hdl/mlr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Midpoint line rasteriser package
// Field widths, the octant code and the control word of the stepping unit.
// ----------------------------------------------------------------------------
package mlr_pkg;

    localparam int FIELD_W = 6;

    typedef enum logic [1:0] {
        OCT_SHALLOW_RISE,
        OCT_STEEP_RISE,
        OCT_SHALLOW_FALL,
        OCT_STEEP_FALL
    } octant_t;

    typedef struct packed {
        logic    load;
        logic    advance;
        octant_t octant;
    } step_ctrl_t;

endpackage
`default_nettype wire

/* hdl/mlr_cmd_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line command channel
// Valid/ready channel that carries the two endpoints of one line.
// ----------------------------------------------------------------------------
interface mlr_cmd_if;
    logic                              valid;
    logic                              ready;
    logic signed [mlr_pkg::FIELD_W-1:0] start_x;
    logic signed [mlr_pkg::FIELD_W-1:0] start_y;
    logic signed [mlr_pkg::FIELD_W-1:0] end_x;
    logic signed [mlr_pkg::FIELD_W-1:0] end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface
`default_nettype wire

/* hdl/mlr_pix_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel that carries one pixel of a line and its end marker.
// ----------------------------------------------------------------------------
interface mlr_pix_if;
    logic                              valid;
    logic                              ready;
    logic signed [mlr_pkg::FIELD_W-1:0] pixel_x;
    logic signed [mlr_pkg::FIELD_W-1:0] pixel_y;
    logic                              last;

    modport source (output valid, pixel_x, pixel_y, last, input ready);
    modport sink (input valid, pixel_x, pixel_y, last, output ready);
endinterface
`default_nettype wire

/* hdl/mlr_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Midpoint stepping unit
// Holds the current pixel, the decision variable and the count of steps left,
// and moves one pixel along the line on each advance.
// ----------------------------------------------------------------------------
module mlr_step #(
    parameter int COORD_BITS = 6
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire mlr_pkg::step_ctrl_t    ctrl,
    input  wire logic signed [COORD_BITS-1:0] x_init,
    input  wire logic signed [COORD_BITS-1:0] y_init,
    input  wire logic signed [COORD_BITS+3:0] d_init,
    input  wire logic signed [COORD_BITS+3:0] inc_taken,
    input  wire logic signed [COORD_BITS+3:0] inc_kept,
    input  wire logic        [COORD_BITS-1:0] steps,
    output logic signed [COORD_BITS-1:0]      x,
    output logic signed [COORD_BITS-1:0]      y,
    output logic                              done
);

    localparam int DW = COORD_BITS + 4;

    mlr_pkg::octant_t        oct_reg;
    logic signed [COORD_BITS-1:0] x_reg, x_next;
    logic signed [COORD_BITS-1:0] y_reg, y_next;
    logic signed [DW-1:0]    d_reg, d_next;
    logic signed [DW-1:0]    inc_t_reg, inc_k_reg;
    logic [COORD_BITS-1:0]   left_reg;
    logic                    taken;
    logic                    d_neg;
    logic                    d_zero;

    assign d_neg  = d_reg[DW-1];
    assign d_zero = (d_reg == '0);

    always_comb
    begin
        unique case (oct_reg)
            mlr_pkg::OCT_SHALLOW_RISE: taken = d_neg;
            mlr_pkg::OCT_STEEP_RISE:   taken = !d_neg && !d_zero;
            mlr_pkg::OCT_SHALLOW_FALL: taken = !d_neg;
            default:                   taken = d_neg || d_zero;
        endcase
    end

    always_comb
    begin
        unique case (oct_reg)
            mlr_pkg::OCT_SHALLOW_RISE:
            begin
                x_next = x_reg + COORD_BITS'(1);
                y_next = taken ? y_reg + COORD_BITS'(1) : y_reg;
            end
            mlr_pkg::OCT_STEEP_RISE:
            begin
                x_next = taken ? x_reg + COORD_BITS'(1) : x_reg;
                y_next = y_reg + COORD_BITS'(1);
            end
            mlr_pkg::OCT_SHALLOW_FALL:
            begin
                x_next = x_reg + COORD_BITS'(1);
                y_next = taken ? y_reg - COORD_BITS'(1) : y_reg;
            end
            default:
            begin
                x_next = taken ? x_reg + COORD_BITS'(1) : x_reg;
                y_next = y_reg - COORD_BITS'(1);
            end
        endcase
        d_next = d_reg + (taken ? inc_t_reg : inc_k_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oct_reg  <= mlr_pkg::OCT_SHALLOW_RISE;
            left_reg <= '0;
        end
        else if (ctrl.load)
        begin
            oct_reg  <= ctrl.octant;
            left_reg <= steps;
        end
        else if (ctrl.advance)
        begin
            left_reg <= left_reg - COORD_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            x_reg     <= x_init;
            y_reg     <= y_init;
            d_reg     <= d_init;
            inc_t_reg <= inc_taken;
            inc_k_reg <= inc_kept;
        end
        else if (ctrl.advance)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            d_reg <= d_next;
        end
    end

    assign x    = x_reg;
    assign y    = y_reg;
    assign done = (left_reg == '0);

endmodule
`default_nettype wire

/* hdl/midpoint_line_rasterizer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Midpoint line rasteriser
// Takes a line command with two signed endpoints and emits every pixel of
// the line in order by the midpoint method, marking the final pixel.
// ----------------------------------------------------------------------------
// A line command is taken only while the block is idle. After the transaction
// the endpoints are ordered in ST_ORDER, and in ST_PLAN the octant, the
// starting decision value and its updates are set; the stepping unit then
// gives one pixel per cycle while the pixel channel does not stall, and a
// line of N pixels (N up to 2**COORD_BITS) keeps the block busy until its
// final pixel is emitted. Only the low COORD_BITS bits of each coordinate are
// used; pixels come out in the low COORD_BITS bits with the upper bits cleared.
module midpoint_line_rasterizer #(
    parameter int COORD_BITS = 6
) (
    input  wire        clk,
    input  wire        rst_n,
    mlr_cmd_if.sink    cmd,
    mlr_pix_if.source  pix
);

    localparam int CW = COORD_BITS;
    localparam int DW = COORD_BITS + 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ORDER,
        ST_PLAN,
        ST_RUN
    } state_t;

    state_t                  state_reg;
    logic signed [CW-1:0]    sx_reg, sy_reg, ex_reg, ey_reg;
    logic signed [CW-1:0]    x0_reg, y0_reg;
    logic signed [CW:0]      dx_reg, dy_reg;
    logic                    swap;
    logic signed [CW-1:0]    x0_next, y0_next, x1_next, y1_next;
    logic signed [CW:0]      ady;
    logic                    shallow;
    logic signed [DW-1:0]    a_ext, b_ext;
    logic signed [DW-1:0]    d_init, inc_taken, inc_kept;
    logic [CW:0]             steps_wide;
    mlr_pkg::octant_t        octant;
    mlr_pkg::step_ctrl_t     ctrl;
    logic signed [CW-1:0]    step_x, step_y;
    logic                    step_done;
    logic                    emit;
    logic                    out_valid_reg;
    logic [mlr_pkg::FIELD_W-1:0] px_reg, py_reg;
    logic                    last_reg;

    assign swap = (ex_reg < sx_reg) || ((ex_reg == sx_reg) && (ey_reg < sy_reg));

    always_comb
    begin
        x0_next = swap ? ex_reg : sx_reg;
        y0_next = swap ? ey_reg : sy_reg;
        x1_next = swap ? sx_reg : ex_reg;
        y1_next = swap ? sy_reg : ey_reg;
    end

    always_comb
    begin
        ady     = dy_reg[CW] ? -dy_reg : dy_reg;
        shallow = (ady <= dx_reg);
        a_ext   = -DW'(dy_reg);
        b_ext   = DW'(dx_reg);
        if (!dy_reg[CW])
        begin
            octant = shallow ? mlr_pkg::OCT_SHALLOW_RISE : mlr_pkg::OCT_STEEP_RISE;
        end
        else
        begin
            octant = shallow ? mlr_pkg::OCT_SHALLOW_FALL : mlr_pkg::OCT_STEEP_FALL;
        end
        unique case (octant)
            mlr_pkg::OCT_SHALLOW_RISE:
            begin
                d_init    = (a_ext <<< 1) + b_ext;
                inc_taken = (a_ext + b_ext) <<< 1;
                inc_kept  = a_ext <<< 1;
            end
            mlr_pkg::OCT_STEEP_RISE:
            begin
                d_init    = a_ext + (b_ext <<< 1);
                inc_taken = (a_ext + b_ext) <<< 1;
                inc_kept  = b_ext <<< 1;
            end
            mlr_pkg::OCT_SHALLOW_FALL:
            begin
                d_init    = (a_ext <<< 1) - b_ext;
                inc_taken = (a_ext - b_ext) <<< 1;
                inc_kept  = a_ext <<< 1;
            end
            default:
            begin
                d_init    = a_ext - (b_ext <<< 1);
                inc_taken = (a_ext - b_ext) <<< 1;
                inc_kept  = -(b_ext <<< 1);
            end
        endcase
        steps_wide = shallow ? $unsigned(dx_reg) : $unsigned(ady);
    end

    assign emit = (state_reg == ST_RUN) && (!out_valid_reg || pix.ready);

    always_comb
    begin
        ctrl.load    = (state_reg == ST_PLAN);
        ctrl.advance = emit && !step_done;
        ctrl.octant  = octant;
    end

    mlr_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .x_init    (x0_reg),
        .y_init    (y0_reg),
        .d_init    (d_init),
        .inc_taken (inc_taken),
        .inc_kept  (inc_kept),
        .steps     (steps_wide[CW-1:0]),
        .x         (step_x),
        .y         (step_y),
        .done      (step_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            px_reg        <= '0;
            py_reg        <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
                px_reg        <= mlr_pkg::FIELD_W'($unsigned(step_x));
                py_reg        <= mlr_pkg::FIELD_W'($unsigned(step_y));
                last_reg      <= step_done;
            end
            else if (pix.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        state_reg <= ST_ORDER;
                    end
                end
                ST_ORDER:
                begin
                    state_reg <= ST_PLAN;
                end
                ST_PLAN:
                begin
                    state_reg <= ST_RUN;
                end
                ST_RUN:
                begin
                    if (emit && step_done)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && cmd.valid)
        begin
            sx_reg <= cmd.start_x[CW-1:0];
            sy_reg <= cmd.start_y[CW-1:0];
            ex_reg <= cmd.end_x[CW-1:0];
            ey_reg <= cmd.end_y[CW-1:0];
        end
        if (state_reg == ST_ORDER)
        begin
            x0_reg <= x0_next;
            y0_reg <= y0_next;
            dx_reg <= (CW+1)'(x1_next) - (CW+1)'(x0_next);
            dy_reg <= (CW+1)'(y1_next) - (CW+1)'(y0_next);
        end
    end

    assign cmd.ready   = (state_reg == ST_IDLE);
    assign pix.valid   = out_valid_reg;
    assign pix.pixel_x = px_reg;
    assign pix.pixel_y = py_reg;
    assign pix.last    = last_reg;

endmodule
`default_nettype wire

/* sim/mlr_pixel_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel stream checker for the midpoint line rasteriser
// Watches the line command and pixel channels, works out the pixels of every
// accepted line by the integer midpoint method and compares each pixel
// transaction, field by field, with the oldest pixel still outstanding.
// ----------------------------------------------------------------------------
module mlr_pixel_checker (
    input  logic clk,
    input  logic rst_n,
    mlr_cmd_if   cmd,
    mlr_pix_if   pix,
    output int   fail_count,
    output int   pixels_outstanding
);

    typedef logic signed [mlr_pkg::FIELD_W-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   last;
    } pixel_t;

    pixel_t expected_pixels[$];
    int     fails = 0;
    int     outstanding = 0;

    assign fail_count         = fails;
    assign pixels_outstanding = outstanding;

    function automatic void push_pixel(int x, int y);
        pixel_t p;
        p.x    = coord_t'(x);
        p.y    = coord_t'(y);
        p.last = 1'b0;
        expected_pixels.push_back(p);
    endfunction

    function automatic void plan_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
        int               x0;
        int               y0;
        int               x1;
        int               y1;
        int               t;
        int               dx;
        int               dy;
        int               d;
        int               x;
        int               y;
        mlr_pkg::octant_t oct;
        x0 = sx;
        y0 = sy;
        x1 = ex;
        y1 = ey;
        if (x1 < x0 || (x1 == x0 && y1 < y0))
        begin
            t = x0; x0 = x1; x1 = t;
            t = y0; y0 = y1; y1 = t;
        end
        dx = x1 - x0;
        dy = y1 - y0;
        x  = x0;
        y  = y0;
        if (dx == 0)
        begin
            for (y = y0; y <= y1; y++)
                push_pixel(x0, y);
        end
        else if (dy == 0)
        begin
            for (x = x0; x <= x1; x++)
                push_pixel(x, y0);
        end
        else
        begin
            if (dy > 0)
                oct = (dy <= dx) ? mlr_pkg::OCT_SHALLOW_RISE : mlr_pkg::OCT_STEEP_RISE;
            else
                oct = (-dy <= dx) ? mlr_pkg::OCT_SHALLOW_FALL : mlr_pkg::OCT_STEEP_FALL;
            push_pixel(x, y);
            case (oct)
                mlr_pkg::OCT_SHALLOW_RISE:
                begin
                    d = dx - 2 * dy;
                    while (x < x1)
                    begin
                        if (d < 0)
                        begin
                            y++;
                            d += 2 * (dx - dy);
                        end
                        else
                            d -= 2 * dy;
                        x++;
                        push_pixel(x, y);
                    end
                end
                mlr_pkg::OCT_STEEP_RISE:
                begin
                    d = 2 * dx - dy;
                    while (y < y1)
                    begin
                        if (d > 0)
                        begin
                            x++;
                            d += 2 * (dx - dy);
                        end
                        else
                            d += 2 * dx;
                        y++;
                        push_pixel(x, y);
                    end
                end
                mlr_pkg::OCT_SHALLOW_FALL:
                begin
                    d = -2 * dy - dx;
                    while (x < x1)
                    begin
                        if (d >= 0)
                        begin
                            y--;
                            d -= 2 * (dy + dx);
                        end
                        else
                            d -= 2 * dy;
                        x++;
                        push_pixel(x, y);
                    end
                end
                default:
                begin
                    d = -dy - 2 * dx;
                    while (y > y1)
                    begin
                        if (d > 0)
                            d -= 2 * dx;
                        else
                        begin
                            x++;
                            d -= 2 * (dy + dx);
                        end
                        y--;
                        push_pixel(x, y);
                    end
                end
            endcase
        end
        expected_pixels[expected_pixels.size() - 1].last = 1'b1;
    endfunction

    always @(posedge clk)
    begin : watch
        int     errs;
        pixel_t want;
        errs = 0;
        if (rst_n)
        begin
            if (pix.valid && pix.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("unexpected pixel transaction: pixel_x %0d, pixel_y %0d, last %0b",
                           pix.pixel_x, pix.pixel_y, pix.last);
                    errs++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pix.pixel_x !== want.x)
                    begin
                        $error("pixel_x: expected %0d, got %0d", want.x, pix.pixel_x);
                        errs++;
                    end
                    if (pix.pixel_y !== want.y)
                    begin
                        $error("pixel_y: expected %0d, got %0d", want.y, pix.pixel_y);
                        errs++;
                    end
                    if (pix.last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, pix.last);
                        errs++;
                    end
                end
            end
            if (cmd.valid && cmd.ready)
                plan_line(cmd.start_x, cmd.start_y, cmd.end_x, cmd.end_y);
        end
        fails       <= fails + errs;
        outstanding <= expected_pixels.size();
    end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint line rasteriser testbench
// Sends directed and random line commands under varying back-pressure,
// including one long stall of the pixel channel, and takes its verdict from
// the pixel stream checker.
// ----------------------------------------------------------------------------
module tb;

    typedef logic signed [mlr_pkg::FIELD_W-1:0] coord_t;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_AT        = 40;
    localparam int RANDOM_LINES   = 52;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic pix_ready = 1'b0;

    int send_idle_pct  = 23;
    int recv_stall_pct = 52;
    int hold_left      = 0;
    int lines_taken    = 0;
    int fail_count;
    int pixels_outstanding;

    mlr_cmd_if cmd_ch ();
    mlr_pix_if pix_ch ();

    assign pix_ch.ready = pix_ready;

    always #2 clk = ~clk;

    midpoint_line_rasterizer #(
        .COORD_BITS (mlr_pkg::FIELD_W)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .pix   (pix_ch)
    );

    mlr_pixel_checker u_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd_ch),
        .pix                (pix_ch),
        .fail_count         (fail_count),
        .pixels_outstanding (pixels_outstanding)
    );

    // Once a set number of lines has gone in, the pixel channel is held off
    // for a long stretch so that the block fills and refuses further commands.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_ready   <= 1'b0;
            hold_left   <= 0;
            lines_taken <= 0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
                lines_taken <= lines_taken + 1;
            if (cmd_ch.valid && cmd_ch.ready && lines_taken == HOLD_AT)
            begin
                hold_left <= LONG_HOLD;
                pix_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                pix_ready <= 1'b0;
            end
            else
                pix_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (pix_ch.valid && pix_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("midpoint_line_rasterizer test failed");
        $finish;
    end

    task automatic send_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.start_x <= sx;
        cmd_ch.start_y <= sy;
        cmd_ch.end_x   <= ex;
        cmd_ch.end_y   <= ey;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pixels_outstanding != 0);
    endtask

    function automatic coord_t any_coord();
        return coord_t'($urandom_range(63));
    endfunction

    function automatic coord_t near_coord(coord_t c);
        int v;
        v = int'(c) + int'($urandom_range(14)) - 7;
        if (v > 31)
            v = 31;
        if (v < -32)
            v = -32;
        return coord_t'(v);
    endfunction

    task automatic random_line();
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        int     k;
        int     x0;
        int     y0;
        sx = any_coord();
        sy = any_coord();
        ex = any_coord();
        ey = any_coord();
        case ($urandom_range(9))
            0: ey = sy;
            1: ex = sx;
            2:
            begin
                ex = sx;
                ey = sy;
            end
            3:
            begin
                k  = $urandom_range(63);
                x0 = int'($urandom_range(63 - k)) - 32;
                if ($urandom_range(1))
                begin
                    y0 = int'($urandom_range(63 - k)) - 32;
                    ey = coord_t'(y0 + k);
                end
                else
                begin
                    y0 = 31 - int'($urandom_range(63 - k));
                    ey = coord_t'(y0 - k);
                end
                sx = coord_t'(x0);
                sy = coord_t'(y0);
                ex = coord_t'(x0 + k);
                if ($urandom_range(1))
                begin
                    {sx, ex} = {ex, sx};
                    {sy, ey} = {ey, sy};
                end
            end
            4, 5:
            begin
                ex = near_coord(sx);
                ey = near_coord(sy);
            end
            default: ;
        endcase
        send_line(sx, sy, ex, ey);
    endtask

    initial
    begin : stimulus
        int phase;
        cmd_ch.valid   = 1'b0;
        cmd_ch.start_x = '0;
        cmd_ch.start_y = '0;
        cmd_ch.end_x   = '0;
        cmd_ch.end_y   = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single points, full-span and reversed straight lines, diagonals,
        // every octant in both directions and the decision-value ties.
        send_line(0, 0, 0, 0);
        send_line(-32, -32, -32, -32);
        send_line(31, 31, 31, 31);
        send_line(-32, 0, 31, 0);
        send_line(31, 5, -32, 5);
        send_line(7, -32, 7, 31);
        send_line(7, 31, 7, -32);
        send_line(0, 0, 10, 4);
        send_line(10, 4, 0, 0);
        send_line(-32, -32, 31, 31);
        send_line(0, 0, 3, 20);
        send_line(3, 20, 0, 0);
        send_line(0, 0, 10, -4);
        send_line(-32, 31, 31, -32);
        send_line(0, 0, 3, -20);
        send_line(3, -20, 0, 0);
        send_line(31, -32, -32, 31);
        send_line(-32, -32, -31, 31);
        send_line(-32, 31, 31, 30);
        send_line(0, 0, 2, 1);
        send_line(0, 0, 1, 2);
        send_line(0, 0, 2, -1);
        send_line(0, 0, 1, -2);
        drain();

        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct   = 23;
                    recv_stall_pct <= 52;
                end
                1:
                begin
                    send_idle_pct   = 52;
                    recv_stall_pct <= 23;
                end
                default:
                begin
                    send_idle_pct   = 0;
                    recv_stall_pct <= 0;
                end
            endcase
            repeat (RANDOM_LINES) random_line();
            drain();
        end

        repeat (20) @(posedge clk);
        if (fail_count == 0 && pixels_outstanding == 0)
            $display("midpoint_line_rasterizer test passed");
        else
            $display("midpoint_line_rasterizer test failed");
        $finish;
    end

endmodule
